// ===== rtl/cra_pkg.sv =====
// Shared types and constants for the cubic audio resampler.
`timescale 1ns / 1ps
package cra_pkg;

  localparam int unsigned MAX_CHANNELS = 2;
  localparam int unsigned TAPS         = 4;
  localparam int unsigned MAX_RESULTS  = 48;
  localparam int unsigned CH_W         = 1;
  localparam int unsigned ADDR_W       = 3;

  localparam logic [20:0] STEP_MIN = 21'd8192;
  localparam logic [20:0] STEP_MAX = 21'd1048576;

  localparam logic [2:0] CFG_BYPASS   = 3'd0;
  localparam logic [2:0] CFG_STEP     = 3'd1;
  localparam logic [2:0] CFG_FRAMES   = 3'd2;
  localparam logic [2:0] CFG_CHANNELS = 3'd3;
  localparam logic [2:0] CFG_FORMAT   = 3'd4;

  typedef enum logic [1:0] {
    FMT_U8    = 2'd0,
    FMT_S8    = 2'd1,
    FMT_S16LE = 2'd2,
    FMT_S16BE = 2'd3
  } fmt_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_WAIT,
    S_ABC,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_FIN,
    S_ENC
  } state_t;

endpackage

// ===== rtl/cubic_audio_resampler.sv =====
// Catmull-Rom cubic resampler: history memory, position control and datapath.
//
//   channel  | direction | handshake         | payload
//   in_      | in        | in_valid/ready    | sample_code, block_end
//   out_     | out       | out_valid/ready   | code, frame_end, run_last
//   cfg_     | in        | cfg_we            | cfg_index, cfg_data
//
// A request that completes no frame and ends no block is taken in the idle state alone; any
// other (outside bypass) moves to the check state, and each result then takes four tap reads from
// the history memory, a wait for the last read, the coefficients, three chained
// multiplies, the clamp and the encode with its multiply.
// Synchronous active-low reset clears control state and history valid bits.
// A stalled output holds the datapath in the encode step; no new request is taken
// until all results of the current one are loaded.
`timescale 1ns / 1ps
module cubic_audio_resampler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_sample_code,
  input  logic        in_block_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_code,
  output logic        out_frame_end,
  output logic        out_run_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import cra_pkg::*;

  localparam int unsigned DEPTH = MAX_CHANNELS * TAPS;

  state_t state_r, state_nxt;

  logic        bypass_r;
  logic [20:0] step_r;
  logic [31:0] frames_r;
  logic [1:0]  chcnt_r;
  fmt_t        fmt_r;

  logic [CH_W-1:0] ci_r;
  logic [31:0]     n_r;
  logic [47:0]     pos_r;
  logic [31:0]     emitted_r;
  logic [5:0]      cnt_r;
  logic            last_r;
  logic            next_go_r;
  logic [CH_W-1:0] c_r;
  logic [1:0]      j_r;
  logic            rd_pend_r;
  logic [1:0]      rd_j_r;

  logic signed [15:0] mem [DEPTH];
  logic [DEPTH-1:0]   vld_r;
  logic signed [15:0] mem_q_r;
  logic               vq_r;

  logic signed [15:0] p_r [TAPS];
  logic signed [19:0] a_r, b_r;
  logic signed [16:0] cc_r;
  logic signed [21:0] h1_r, h2_r, h3_r;
  logic signed [16:0] y_r;

  logic        out_valid_r, out_frame_end_r, out_run_last_r;
  logic [15:0] out_code_r;

  // control
  logic              in_fire, out_free, two_ch, mem_we, mem_re, enc_load;
  logic [CH_W-1:0]   ch, last_ch;
  logic              completed;
  logic signed [15:0] dec;
  logic [ADDR_W-1:0] wa, ra;
  logic [20:0]       step_sat;
  logic [47:0]       pos_next;
  logic signed [33:0] limit, idx_s, idx_n_s, k, lo, hi, kc;
  logic [6:0]        chans7;
  logic              go, next_go;

  assign out_free = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign two_ch   = chcnt_r >= 2'd2;
  assign last_ch  = two_ch ? 1'b1 : 1'b0;
  assign ch       = two_ch ? ci_r : 1'b0;
  assign completed = ch == last_ch;
  assign chans7   = two_ch ? 7'd2 : 7'd1;

  always_comb begin
    case (fmt_r)
      FMT_U8:    dec = {in_sample_code[7:0] ^ 8'h80, 8'h00};
      FMT_S8:    dec = {in_sample_code[7:0], 8'h00};
      FMT_S16LE: dec = in_sample_code;
      FMT_S16BE: dec = {in_sample_code[7:0], in_sample_code[15:8]};
      default:   dec = in_sample_code;
    endcase
  end

  always_comb begin
    if (step_r < STEP_MIN) begin
      step_sat = STEP_MIN;
    end else if (step_r > STEP_MAX) begin
      step_sat = STEP_MAX;
    end else begin
      step_sat = step_r;
    end
  end

  assign pos_next = pos_r + {27'd0, step_sat};
  assign limit    = $signed({2'b00, n_r}) - (last_r ? 34'sd1 : 34'sd3);
  assign idx_s    = $signed({2'b00, pos_r[47:16]});
  assign idx_n_s  = $signed({2'b00, pos_next[47:16]});
  assign go       = (n_r != 32'd0) && (emitted_r < frames_r) &&
                    ({1'b0, cnt_r} + chans7 <= 7'(MAX_RESULTS)) && (idx_s <= limit);
  assign next_go  = ({1'b0, emitted_r} + 33'd1 < {1'b0, frames_r}) &&
                    ({1'b0, cnt_r} + chans7 + chans7 <= 7'(MAX_RESULTS)) &&
                    (idx_n_s <= limit);

  assign k  = idx_s - 34'sd1 + $signed({32'd0, j_r});
  assign lo = (n_r >= 32'd4) ? $signed({2'b00, n_r}) - 34'sd4 : 34'sd0;
  assign hi = $signed({2'b00, n_r}) - 34'sd1;
  always_comb begin
    if (k < lo) begin
      kc = lo;
    end else if (k > hi) begin
      kc = hi;
    end else begin
      kc = k;
    end
  end

  assign wa = {ch, n_r[1:0]};
  assign ra = {c_r, kc[1:0]};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire && !bypass_r && (completed || in_block_end)) state_nxt = S_CHECK;
      S_CHECK: state_nxt = go ? S_READ : S_IDLE;
      S_READ:  if (j_r == 2'd3) state_nxt = S_WAIT;
      S_WAIT:  state_nxt = S_ABC;
      S_ABC:   state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_MUL3;
      S_MUL3:  state_nxt = S_FIN;
      S_FIN:   state_nxt = S_ENC;
      S_ENC:   if (out_free) state_nxt = (c_r == last_ch) ? S_CHECK : S_READ;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready = 1'b0;
    mem_re   = 1'b0;
    enc_load = 1'b0;
    case (state_r)
      S_IDLE:  in_ready = out_free;
      S_READ:  mem_re = 1'b1;
      S_ENC:   enc_load = out_free;
      default: in_ready = 1'b0;
    endcase
  end

  assign mem_we = in_fire && !bypass_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wa] <= dec;
    end
    mem_q_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r <= 1'b0;
      step_r   <= 21'd65536;
      frames_r <= 32'd0;
      chcnt_r  <= 2'd1;
      fmt_r    <= FMT_S16LE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BYPASS:   bypass_r <= cfg_data[0];
        CFG_STEP:     step_r   <= cfg_data[20:0];
        CFG_FRAMES:   frames_r <= cfg_data;
        CFG_CHANNELS: chcnt_r  <= cfg_data[1:0];
        CFG_FORMAT:   fmt_r    <= fmt_t'(cfg_data[1:0]);
        default:      bypass_r <= bypass_r;
      endcase
    end
  end

  // history valid bits and read tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      vq_r      <= 1'b0;
      rd_pend_r <= 1'b0;
      rd_j_r    <= 2'd0;
    end else begin
      if (mem_we) begin
        vld_r[wa] <= 1'b1;
      end
      vq_r      <= vld_r[ra];
      rd_pend_r <= mem_re;
      rd_j_r    <= j_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      p_r[rd_j_r] <= vq_r ? mem_q_r : 16'sd0;
    end
  end

  // block counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ci_r      <= '0;
      n_r       <= 32'd0;
      pos_r     <= 48'd0;
      emitted_r <= 32'd0;
      cnt_r     <= 6'd0;
      last_r    <= 1'b0;
      next_go_r <= 1'b0;
      c_r       <= '0;
      j_r       <= 2'd0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            ci_r   <= (completed || (bypass_r && in_block_end)) ? '0 : ~ch;
            cnt_r  <= 6'd0;
            last_r <= in_block_end;
            if (!bypass_r && completed) begin
              n_r <= n_r + 32'd1;
            end
            if (bypass_r && in_block_end) begin
              n_r       <= 32'd0;
              pos_r     <= 48'd0;
              emitted_r <= 32'd0;
            end
          end
        end
        S_CHECK: begin
          c_r       <= '0;
          j_r       <= 2'd0;
          next_go_r <= next_go;
          if (!go && last_r) begin
            ci_r      <= '0;
            n_r       <= 32'd0;
            pos_r     <= 48'd0;
            emitted_r <= 32'd0;
          end
        end
        S_READ: j_r <= j_r + 2'd1;
        S_ENC: begin
          if (out_free) begin
            cnt_r <= cnt_r + 6'd1;
            j_r   <= 2'd0;
            if (c_r == last_ch) begin
              pos_r     <= pos_next;
              emitted_r <= emitted_r + 32'd1;
              c_r       <= '0;
            end else begin
              c_r <= c_r + 1'b1;
            end
          end
        end
        default: j_r <= j_r;
      endcase
    end
  end

  // interpolation datapath
  logic signed [19:0] pe [TAPS];
  logic signed [16:0] t_s;
  logic signed [36:0] prod1, rs1;
  logic signed [38:0] prod2, rs2, prod3, rs3;
  logic signed [22:0] sum;
  logic signed [22:0] ys;

  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      pe[i] = 20'(p_r[i]);
    end
  end

  assign t_s   = $signed({1'b0, pos_r[15:0]});
  assign prod1 = a_r * t_s;
  assign rs1   = (prod1 + 37'sd32768) >>> 16;
  assign prod2 = h1_r * t_s;
  assign rs2   = (prod2 + 39'sd32768) >>> 16;
  assign prod3 = h2_r * t_s;
  assign rs3   = (prod3 + 39'sd32768) >>> 16;
  assign sum   = 23'(h3_r) + 23'(p_r[1]) + 23'(p_r[1]) + 23'sd1;
  assign ys    = sum >>> 1;

  always_ff @(posedge clk) begin
    case (state_r)
      S_ABC: begin
        a_r  <= -pe[0] + 20'sd3 * pe[1] - 20'sd3 * pe[2] + pe[3];
        b_r  <= 20'sd2 * pe[0] - 20'sd5 * pe[1] + 20'sd4 * pe[2] - pe[3];
        cc_r <= 17'(p_r[2]) - 17'(p_r[0]);
      end
      S_MUL1: h1_r <= rs1[21:0] + 22'(b_r);
      S_MUL2: h2_r <= rs2[21:0] + 22'(cc_r);
      S_MUL3: h3_r <= rs3[21:0];
      S_FIN: begin
        if (ys < -23'sd32768) begin
          y_r <= -17'sd32768;
        end else if (ys > 23'sd32768) begin
          y_r <= 17'sd32768;
        end else begin
          y_r <= ys[16:0];
        end
      end
      default: y_r <= y_r;
    endcase
  end

  // re-encode
  logic signed [17:0] yu;
  logic [8:0]         v8;
  logic signed [16:0] coef;
  logic signed [33:0] m, mneg, mt;
  logic [15:0]        enc;

  assign yu   = 18'(y_r) + 18'sd32768;
  assign v8   = yu[16:8];
  assign coef = (fmt_r == FMT_S8) ? 17'sd127 : 17'sd32767;
  assign m    = y_r * coef;
  assign mneg = -m;
  assign mt   = m[33] ? -(mneg >>> 15) : (m >>> 15);

  always_comb begin
    case (fmt_r)
      FMT_U8:    enc = {8'd0, (v8 > 9'd255) ? 8'hFF : v8[7:0]};
      FMT_S8:    enc = {8'd0, mt[7:0]};
      FMT_S16LE: enc = mt[15:0];
      FMT_S16BE: enc = {mt[7:0], mt[15:8]};
      default:   enc = mt[15:0];
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && bypass_r) begin
      out_valid_r <= 1'b1;
    end else if (enc_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && bypass_r) begin
      out_code_r      <= (fmt_r == FMT_U8 || fmt_r == FMT_S8) ?
                         {8'd0, in_sample_code[7:0]} : in_sample_code;
      out_frame_end_r <= completed;
      out_run_last_r  <= 1'b1;
    end else if (enc_load) begin
      out_code_r      <= enc;
      out_frame_end_r <= c_r == last_ch;
      out_run_last_r  <= (c_r == last_ch) && !next_go_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_code      = out_code_r;
  assign out_frame_end = out_frame_end_r;
  assign out_run_last  = out_run_last_r;

`ifndef NO_ASSERTIONS
  a_in_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE)
    else $error("request taken outside idle");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 6'(MAX_RESULTS))
    else $error("result count above limit");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    enc_load && (c_r == last_ch) && !next_go_r |=> state_r == S_CHECK)
    else $error("final result not followed by check");

  a_no_read_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |-> !mem_we)
    else $error("history read and written together");
`endif

endmodule
